// File: hw/rtl/crfe_pkg.sv
// Shared constants and types for the clipped rectangle fill engine.
package crfe_pkg;

	// Default store geometry
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 256;

	// Register port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Bits of a register write that count before saturation
	localparam int CFG_HORZ_W = 10;
	localparam int CFG_VERT_W = 9;

	// Register reset values before clamping to the store geometry
	localparam int RST_SCREEN_W = 512;
	localparam int RST_SCREEN_H = 256;

	// Field widths of an item
	localparam int CMD_W   = 2;
	localparam int COORD_W = 17;
	localparam int COLOR_W = 32;
	// Coordinate width once a width or height has been added
	localparam int SUM_W   = COORD_W + 1;

	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_CLIP_LEFT     = 3'd2,
		REG_CLIP_TOP      = 3'd3,
		REG_CLIP_RIGHT    = 3'd4,
		REG_CLIP_BOTTOM   = 3'd5
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILL  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

endpackage

// File: hw/rtl/crfe_ram.sv
// Generic single-port RAM with registered read data.
module crfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: hw/rtl/crfe_regs.sv
// Register file for screen size and clip window, with saturating writes.
module crfe_regs #(
	parameter int MAX_WIDTH  = crfe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = crfe_pkg::MAX_HEIGHT_DEF,
	localparam int XW = $clog2(MAX_WIDTH + 1),
	localparam int YW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [crfe_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [crfe_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [crfe_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output logic [XW-1:0]                    screen_width,
	output logic [YW-1:0]                    screen_height,
	output logic [XW-1:0]                    clip_left,
	output logic [YW-1:0]                    clip_top,
	output logic [XW-1:0]                    clip_right,
	output logic [YW-1:0]                    clip_bottom
);

	localparam int RST_SW = (crfe_pkg::RST_SCREEN_W > MAX_WIDTH) ?
		MAX_WIDTH : crfe_pkg::RST_SCREEN_W;
	localparam int RST_SH = (crfe_pkg::RST_SCREEN_H > MAX_HEIGHT) ?
		MAX_HEIGHT : crfe_pkg::RST_SCREEN_H;

	logic [XW-1:0] sw_q, cl_q, cr_q;
	logic [YW-1:0] sh_q, ct_q, cb_q;
	logic [31:0]   vh, vv;
	logic [XW-1:0] sw_sat, horz_sat;
	logic [YW-1:0] sh_sat, vert_sat;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	// Saturate the masked write value into range
	assign vh = 32'(pwdata[crfe_pkg::CFG_HORZ_W-1:0]);
	assign vv = 32'(pwdata[crfe_pkg::CFG_VERT_W-1:0]);

	always_comb begin
		horz_sat = (vh > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(vh);
		vert_sat = (vv > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(vv);
		sw_sat   = (vh == 32'd0) ? XW'(1) : horz_sat;
		sh_sat   = (vv == 32'd0) ? YW'(1) : vert_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= XW'(RST_SW);
			sh_q <= YW'(RST_SH);
			cl_q <= '0;
			ct_q <= '0;
			cr_q <= XW'(RST_SW);
			cb_q <= YW'(RST_SH);
		end else if (wr_en) begin
			unique case (idx)
				crfe_pkg::REG_SCREEN_WIDTH:  sw_q <= sw_sat;
				crfe_pkg::REG_SCREEN_HEIGHT: sh_q <= sh_sat;
				crfe_pkg::REG_CLIP_LEFT:     cl_q <= horz_sat;
				crfe_pkg::REG_CLIP_TOP:      ct_q <= vert_sat;
				crfe_pkg::REG_CLIP_RIGHT:    cr_q <= horz_sat;
				crfe_pkg::REG_CLIP_BOTTOM:   cb_q <= vert_sat;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			crfe_pkg::REG_SCREEN_WIDTH:  prdata = 32'(sw_q);
			crfe_pkg::REG_SCREEN_HEIGHT: prdata = 32'(sh_q);
			crfe_pkg::REG_CLIP_LEFT:     prdata = 32'(cl_q);
			crfe_pkg::REG_CLIP_TOP:      prdata = 32'(ct_q);
			crfe_pkg::REG_CLIP_RIGHT:    prdata = 32'(cr_q);
			crfe_pkg::REG_CLIP_BOTTOM:   prdata = 32'(cb_q);
			default:                     prdata = '0;
		endcase
	end

	assign screen_width  = sw_q;
	assign screen_height = sh_q;
	assign clip_left     = cl_q;
	assign clip_top      = ct_q;
	assign clip_right    = cr_q;
	assign clip_bottom   = cb_q;

endmodule

// File: hw/rtl/clipped_rect_fill_engine_top.sv
// Steps: capture, setup, base address, then a walk of the clipped rectangle for a fill
// (one pixel written per cycle on the single store port), of the whole screen for a
// clear, or a store read for a read inside the screen; an empty fill, an off-screen read
// or an unused command goes from setup to the result. One item at a time: the next beat
// is taken in the cycle after the result is registered, later while an old result waits.
// Reset restores the registers and control; store contents stay undefined.
module clipped_rect_fill_engine_top #(
	parameter int MAX_WIDTH  = crfe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = crfe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crfe_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [crfe_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [crfe_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [crfe_pkg::CMD_W-1:0]          cmd,
	input  logic signed [crfe_pkg::COORD_W-1:0] pos_x,
	input  logic signed [crfe_pkg::COORD_W-1:0] pos_y,
	input  logic signed [crfe_pkg::COORD_W-1:0] rect_w,
	input  logic signed [crfe_pkg::COORD_W-1:0] rect_h,
	input  logic [crfe_pkg::COLOR_W-1:0]        color,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [crfe_pkg::COLOR_W-1:0]        pixel_value,
	output logic                                read_ok
);

	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = XW + YW + 1;
	localparam int EW    = crfe_pkg::SUM_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_BASE,
		ST_WALK,
		ST_RD,
		ST_RDW,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [XW-1:0] screen_width, clip_left, clip_right;
	logic [YW-1:0] screen_height, clip_top, clip_bottom;

	crfe_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.screen_width (screen_width),
		.screen_height(screen_height),
		.clip_left    (clip_left),
		.clip_top     (clip_top),
		.clip_right   (clip_right),
		.clip_bottom  (clip_bottom)
	);

	// Captured item
	logic [crfe_pkg::CMD_W-1:0]          cmd_q;
	logic signed [crfe_pkg::COORD_W-1:0] px_q, py_q, rw_q, rh_q;
	logic [crfe_pkg::COLOR_W-1:0]        color_q;

	// Clipped bounds, walker position and result
	logic [XW-1:0]                x0_q, x1_q, xx_q;
	logic [YW-1:0]                y0_q, y1_q, yy_q;
	logic [AW-1:0]                base_q, row_q, addr_q;
	logic [crfe_pkg::COLOR_W-1:0] res_pix_q;
	logic                         res_ok_q;

	// Setup arithmetic
	logic signed [EW-1:0] px_e, py_e, xe_e, ye_e;
	logic signed [EW-1:0] cl_e, ct_e, cr_e, cb_e, sw_e, sh_e;
	logic signed [EW-1:0] fx0, fx1a, fx1, fy0, fy1a, fy1;
	logic                 fill_empty, rd_in;
	logic [PW-1:0]        base_prod;
	logic                 x_last, y_last;
	logic                 in_acc, out_free;

	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_addr;
	logic [crfe_pkg::COLOR_W-1:0] ram_rdata;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		px_e = EW'(px_q);
		py_e = EW'(py_q);
		xe_e = px_e + EW'(rw_q);
		ye_e = py_e + EW'(rh_q);
		cl_e = signed'(EW'(clip_left));
		ct_e = signed'(EW'(clip_top));
		cr_e = signed'(EW'(clip_right));
		cb_e = signed'(EW'(clip_bottom));
		sw_e = signed'(EW'(screen_width));
		sh_e = signed'(EW'(screen_height));
		// Clip edges are never negative, so the lower clamp also clamps at zero
		fx0  = (px_e > cl_e) ? px_e : cl_e;
		fy0  = (py_e > ct_e) ? py_e : ct_e;
		fx1a = (xe_e < cr_e) ? xe_e : cr_e;
		fy1a = (ye_e < cb_e) ? ye_e : cb_e;
		fx1  = (fx1a < sw_e) ? fx1a : sw_e;
		fy1  = (fy1a < sh_e) ? fy1a : sh_e;
		fill_empty = (fx0 >= fx1) || (fy0 >= fy1);
		rd_in = (px_e >= 0) && (px_e < sw_e) && (py_e >= 0) && (py_e < sh_e);
	end

	assign base_prod = PW'(y0_q) * PW'(screen_width) + PW'(x0_q);
	assign x_last    = (xx_q + XW'(1)) == x1_q;
	assign y_last    = (yy_q + YW'(1)) == y1_q;

	// Control and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid   <= 1'b0;
			pixel_value <= '0;
			read_ok     <= 1'b0;
		end else begin
			// Drop a taken beat; the done state below refills the register itself
			if (out_valid && !out_stall && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					case (cmd_q)
						crfe_pkg::CMD_FILL:  state_q <= fill_empty ? ST_DONE : ST_BASE;
						crfe_pkg::CMD_CLEAR: state_q <= ST_BASE;
						crfe_pkg::CMD_READ:  state_q <= rd_in ? ST_BASE : ST_DONE;
						default:             state_q <= ST_DONE;
					endcase
				end
				ST_BASE: begin
					state_q <= (cmd_q == crfe_pkg::CMD_READ) ? ST_RD : ST_WALK;
				end
				ST_WALK: begin
					if (x_last && y_last) state_q <= ST_DONE;
				end
				ST_RD: begin
					state_q <= ST_RDW;
				end
				ST_RDW: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (out_free) begin
						out_valid   <= 1'b1;
						pixel_value <= res_pix_q;
						read_ok     <= res_ok_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= cmd;
			px_q    <= pos_x;
			py_q    <= pos_y;
			rw_q    <= rect_w;
			rh_q    <= rect_h;
			color_q <= color;
		end
		if (state_q == ST_SETUP) begin
			res_pix_q <= '0;
			res_ok_q  <= 1'b0;
			case (cmd_q)
				crfe_pkg::CMD_CLEAR: begin
					x0_q <= '0;
					x1_q <= screen_width;
					y0_q <= '0;
					y1_q <= screen_height;
				end
				crfe_pkg::CMD_READ: begin
					x0_q     <= XW'(px_e);
					x1_q     <= '0;
					y0_q     <= YW'(py_e);
					y1_q     <= '0;
					res_ok_q <= rd_in;
				end
				default: begin
					x0_q <= XW'(fx0);
					x1_q <= XW'(fx1);
					y0_q <= YW'(fy0);
					y1_q <= YW'(fy1);
				end
			endcase
		end
		if (state_q == ST_BASE) begin
			base_q <= base_prod[AW-1:0];
			row_q  <= base_prod[AW-1:0];
			addr_q <= base_prod[AW-1:0];
			xx_q   <= x0_q;
			yy_q   <= y0_q;
		end
		if (state_q == ST_WALK) begin
			if (x_last) begin
				// Advance to the start of the next row
				xx_q   <= x0_q;
				yy_q   <= yy_q + YW'(1);
				row_q  <= row_q + AW'(screen_width);
				addr_q <= row_q + AW'(screen_width);
			end else begin
				xx_q   <= xx_q + XW'(1);
				addr_q <= addr_q + AW'(1);
			end
		end
		if (state_q == ST_RDW) begin
			res_pix_q <= ram_rdata;
		end
	end

	assign ram_we   = (state_q == ST_WALK);
	assign ram_re   = (state_q == ST_RD);
	assign ram_addr = ram_we ? addr_q : base_q;

	crfe_ram #(
		.WIDTH(crfe_pkg::COLOR_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(color_q),
		.rdata(ram_rdata)
	);

	// The walker stays inside the clipped rectangle
	a_walk_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (xx_q < x1_q) && (yy_q < y1_q))
		else $error("walker left the clipped rectangle");

	// A result that cannot be handed over is not dropped
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid && out_stall) |=> state_q == ST_DONE)
		else $error("result lost while output stalled");

	// A result without a valid read carries no pixel
	a_zero_if_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !read_ok) |-> pixel_value == '0)
		else $error("nonzero pixel without read_ok");

endmodule
